>>> rtl/wovs_pkg.sv
// shared types and constants of the weighted oldest victim selector
package wovs_pkg;

  localparam logic [30:0] INT_MAX = 31'h7FFF_FFFF;

  // register indexes, byte address is 4 * index
  localparam logic [2:0] REG_TYPE_ENABLE = 3'd0;
  localparam logic [2:0] REG_KEEP_MIN_0  = 3'd1;
  localparam logic [2:0] REG_KEEP_MIN_3  = 3'd4;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_TAKE   = 2'd1,
    CMD_CLEAR  = 2'd2
  } wovs_cmd_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_DISABLED = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_NONE     = 2'd3
  } wovs_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLR,
    S_SEL,
    S_SCAN,
    S_FIN
  } wovs_state_t;

  typedef struct packed {
    logic        ins;
    logic        take;
    logic        clr;
    logic [1:0]  cat;
    logic [15:0] handle;
    logic [39:0] bytes;
    logic [39:0] stamp;
  } wovs_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  vcat;
    logic [15:0] handle;
    logic [39:0] bytes;
    logic [39:0] stamp;
  } wovs_res_t;

  typedef struct packed {
    logic        valid;
    logic [39:0] stamp;
    logic [39:0] bytes;
    logic [15:0] handle;
    logic [15:0] age;
  } wovs_slot_t;

  typedef struct packed {
    logic [3:0]       en;
    logic [3:0][15:0] km;
  } wovs_cfg_t;

  function automatic logic [30:0] eff_min(input logic [15:0] km);
    eff_min = (km == 16'd0) ? INT_MAX : {15'd0, km};
  endfunction

endpackage

>>> rtl/wovs_front.sv
// front end: accepts transactions, decodes the command, two-entry queue
module wovs_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          in_command,
  input  logic [1:0]          in_category,
  input  logic [15:0]         in_file_handle,
  input  logic [39:0]         in_file_bytes,
  input  logic [39:0]         in_stamp,
  input  logic                busy,
  output logic                q_vld,
  output wovs_pkg::wovs_item_t q_item,
  input  logic                q_take
);
  import wovs_pkg::*;

  wovs_item_t mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       acc;
  wovs_item_t dec;

  assign full  = (cnt_r == 2'd2) || busy;
  assign acc   = push && !full;
  assign q_vld = (cnt_r != 2'd0);
  assign q_item = mem_r[rp_r];

  always_comb begin
    dec        = '0;
    dec.cat    = in_category;
    dec.handle = in_file_handle;
    dec.bytes  = in_file_bytes;
    dec.stamp  = in_stamp;
    unique case (in_command)
      CMD_INSERT: dec.ins  = 1'b1;
      CMD_TAKE:   dec.take = 1'b1;
      CMD_CLEAR:  dec.clr  = 1'b1;
      default:    dec.ins  = 1'b0;
    endcase
  end

  always_comb begin
    wp_nxt  = wp_r + 1'(acc);
    rp_nxt  = rp_r + 1'(q_take);
    cnt_nxt = cnt_r + 2'(acc) - 2'(q_take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      mem_r[wp_r] <= dec;
    end
  end

endmodule

>>> rtl/wovs_back.sv
// back end: category choice, slot scans over the candidate memory, result register
module wovs_back #(
  parameter int NC  = 4,
  parameter int SPC = 16,
  parameter int TW  = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wovs_pkg::wovs_cfg_t  cfg,
  input  logic                 q_vld,
  input  wovs_pkg::wovs_item_t q_item,
  output logic                 q_take,
  output logic                 busy,
  output logic                 out_vld,
  output wovs_pkg::wovs_res_t  out_res,
  output logic [TW-1:0]        total,
  input  logic                 out_take
);
  import wovs_pkg::*;

  localparam int TOTAL = NC * SPC;
  localparam int AW = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int SW = (SPC > 1) ? $clog2(SPC) : 1;
  localparam int IW = $clog2(SPC + 1);
  localparam int KW = $clog2(SPC + 1);
  localparam int PW = KW + 31;

  wovs_slot_t mem [TOTAL];
  wovs_slot_t rdata_r, wdata;
  logic            we, rd_en;
  logic [AW-1:0]   waddr, raddr;

  wovs_state_t      state_r, state_nxt;
  wovs_item_t       cur_r, cur_nxt;
  logic             init_r, init_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic [3:0][KW-1:0] cnt_r, cnt_nxt;
  logic [TW-1:0]    total_r, total_nxt;
  logic [15:0]      serial_r, serial_nxt;
  logic [1:0]       sel_r, sel_nxt, best_r, best_nxt;
  logic             found_r, found_nxt;
  logic [IW-1:0]    issue_r, issue_nxt;
  logic             pv_r, pv_nxt;
  logic [SW-1:0]    pidx_r, pidx_nxt;
  logic             have_r, have_nxt, free_have_r, free_have_nxt;
  logic [SW-1:0]    pick_r, pick_nxt, free_r, free_nxt;
  logic [15:0]      pold_r, pold_nxt;
  wovs_slot_t       pslot_r, pslot_nxt;
  logic             ovld_r, ovld_nxt;
  wovs_res_t        ores_r, ores_nxt;

  logic [1:0]       scat;
  logic [AW-1:0]    base;
  logic [PW-1:0]    lhs, rhs;
  logic [15:0]      old;
  logic             sel_en, bnew_found;
  logic [1:0]       bnew;

  function automatic logic cat_en(input logic [1:0] c, input logic [3:0] en);
    cat_en = (32'(c) < NC) && en[c];
  endfunction

  assign busy    = init_r;
  assign out_vld = ovld_r;
  assign out_res = ores_r;
  assign total   = total_r;

  assign scat = cur_r.take ? best_r : cur_r.cat;
  assign base = AW'(AW'(scat) * AW'(SPC));
  assign old  = serial_r - rdata_r.age;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  always_comb begin
    state_nxt = state_r;   cur_nxt = cur_r;       init_nxt = init_r;
    clr_nxt = clr_r;       cnt_nxt = cnt_r;       total_nxt = total_r;
    serial_nxt = serial_r; sel_nxt = sel_r;       best_nxt = best_r;
    found_nxt = found_r;   issue_nxt = issue_r;   pv_nxt = 1'b0;
    pidx_nxt = pidx_r;     have_nxt = have_r;     free_have_nxt = free_have_r;
    pick_nxt = pick_r;     free_nxt = free_r;     pold_nxt = pold_r;
    pslot_nxt = pslot_r;   ores_nxt = ores_r;
    ovld_nxt = ovld_r && !out_take;
    q_take = 1'b0; we = 1'b0; rd_en = 1'b0;
    waddr = clr_r; raddr = base; wdata = '0;
    lhs = '0; rhs = '0; sel_en = 1'b0; bnew = best_r; bnew_found = found_r;

    unique case (state_r)
      S_IDLE: begin
        if (q_vld && !ovld_r) begin
          q_take   = 1'b1;
          cur_nxt  = q_item;
          ores_nxt = '0;
          if (q_item.clr) begin
            clr_nxt   = '0;
            state_nxt = S_CLR;
          end else if (q_item.take) begin
            sel_nxt   = '0;
            found_nxt = 1'b0;
            best_nxt  = '0;
            state_nxt = S_SEL;
          end else if (q_item.ins) begin
            if (!cat_en(q_item.cat, cfg.en)) begin
              ores_nxt.status = STAT_DISABLED;
              ovld_nxt = 1'b1;
            end else if (cnt_r[q_item.cat] >= KW'(SPC)) begin
              ores_nxt.status = STAT_FULL;
              ovld_nxt = 1'b1;
            end else begin
              issue_nxt = '0;
              free_have_nxt = 1'b0;
              state_nxt = S_SCAN;
            end
          end else begin
            ores_nxt.status = STAT_OK;
            ovld_nxt = 1'b1;
          end
        end
      end
      S_CLR: begin
        we      = 1'b1;
        waddr   = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(TOTAL - 1)) begin
          state_nxt = S_IDLE;
          if (init_r) begin
            init_nxt = 1'b0;
          end else begin
            cnt_nxt   = '0;
            total_nxt = '0;
            ores_nxt  = '0;
            ovld_nxt  = 1'b1;
          end
        end
      end
      S_SEL: begin
        sel_en = cat_en(sel_r, cfg.en);
        lhs = PW'(cnt_r[best_r]) * PW'(eff_min(cfg.km[sel_r]));
        rhs = PW'(cnt_r[sel_r]) * PW'(eff_min(cfg.km[best_r]));
        if (sel_en) begin
          if (!found_r) begin
            bnew = sel_r;
            bnew_found = 1'b1;
          end else if (lhs < rhs) begin
            bnew = sel_r;
          end
        end
        best_nxt  = bnew;
        found_nxt = bnew_found;
        sel_nxt   = sel_r + 1'b1;
        if (32'(sel_r) == NC - 1) begin
          if (total_r == '0 || !bnew_found || cnt_r[bnew] == '0) begin
            ores_nxt.status = STAT_NONE;
            ovld_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            issue_nxt = '0;
            have_nxt  = 1'b0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (issue_r < IW'(SPC)) begin
          rd_en     = 1'b1;
          raddr     = base + AW'(issue_r[SW-1:0]);
          issue_nxt = issue_r + 1'b1;
          pv_nxt    = 1'b1;
          pidx_nxt  = issue_r[SW-1:0];
        end
        if (pv_r) begin
          if (cur_r.ins) begin
            if (!rdata_r.valid && !free_have_r) begin
              free_have_nxt = 1'b1;
              free_nxt = pidx_r;
            end
          end else if (rdata_r.valid) begin
            if (!have_r || rdata_r.stamp < pslot_r.stamp ||
                (rdata_r.stamp == pslot_r.stamp && old > pold_r)) begin
              have_nxt  = 1'b1;
              pick_nxt  = pidx_r;
              pold_nxt  = old;
              pslot_nxt = rdata_r;
            end
          end
          if (pidx_r == SW'(SPC - 1)) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        state_nxt = S_IDLE;
        ovld_nxt  = 1'b1;
        if (cur_r.ins) begin
          we    = 1'b1;
          waddr = base + AW'(free_r);
          wdata = '{valid: 1'b1, stamp: cur_r.stamp, bytes: cur_r.bytes,
                    handle: cur_r.handle, age: serial_r};
          serial_nxt = serial_r + 16'd1;
          cnt_nxt[cur_r.cat] = cnt_r[cur_r.cat] + 1'b1;
          total_nxt = total_r + 1'b1;
          ores_nxt.status = STAT_OK;
        end else if (!have_r) begin
          ores_nxt.status = STAT_NONE;
        end else begin
          we    = 1'b1;
          waddr = base + AW'(pick_r);
          wdata = '0;
          cnt_nxt[best_r] = cnt_r[best_r] - 1'b1;
          total_nxt = total_r - 1'b1;
          ores_nxt = '{status: STAT_OK, vcat: best_r, handle: pslot_r.handle,
                       bytes: pslot_r.bytes, stamp: pslot_r.stamp};
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      init_r   <= 1'b1;
      clr_r    <= '0;
      cnt_r    <= '0;
      total_r  <= '0;
      serial_r <= '0;
      ovld_r   <= 1'b0;
      pv_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      init_r   <= init_nxt;
      clr_r    <= clr_nxt;
      cnt_r    <= cnt_nxt;
      total_r  <= total_nxt;
      serial_r <= serial_nxt;
      ovld_r   <= ovld_nxt;
      pv_r     <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;       sel_r <= sel_nxt;       best_r <= best_nxt;
    found_r <= found_nxt;   issue_r <= issue_nxt;   pidx_r <= pidx_nxt;
    have_r <= have_nxt;     free_have_r <= free_have_nxt;
    pick_r <= pick_nxt;     free_r <= free_nxt;     pold_r <= pold_nxt;
    pslot_r <= pslot_nxt;   ores_r <= ores_nxt;
  end

endmodule

>>> rtl/weighted_oldest_victim_select.sv
// top level of the weighted oldest victim selector
// A store of NUM_CATEGORIES x SLOTS_PER_CATEGORY deletion candidates in one
// memory with a registered read port. Commands enter a two-entry queue and
// are run one at a time; the next command starts only after the previous
// result has been popped. An insert scans its category's slots for the first
// free one. A take walks all categories one per cycle, then scans the chosen
// category for the oldest candidate. Rejected inserts, unused commands and a
// take with nothing to remove skip the slot scan. A clear writes every slot
// invalid, one per cycle. After reset the same clearing pass runs and full
// stays high until it ends; register writes are taken anyway.
module weighted_oldest_victim_select #(
  parameter int NUM_CATEGORIES     = 4,
  parameter int SLOTS_PER_CATEGORY = 16,
  localparam int TW = $clog2(NUM_CATEGORIES * SLOTS_PER_CATEGORY + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  // register port
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  // input transactions
  input  logic          push,
  output logic          full,
  input  logic [1:0]    in_command,
  input  logic [1:0]    in_category,
  input  logic [15:0]   in_file_handle,
  input  logic [39:0]   in_file_bytes,
  input  logic [39:0]   in_stamp,
  // result transactions
  output logic          empty,
  input  logic          pop,
  output logic [1:0]    out_status,
  output logic [1:0]    out_victim_category,
  output logic [15:0]   out_victim_handle,
  output logic [39:0]   out_victim_bytes,
  output logic [39:0]   out_victim_stamp,
  output logic [TW-1:0] out_pending_total
);
  import wovs_pkg::*;

  wovs_cfg_t  cfg_r, cfg_nxt;
  logic       cfg_wr;
  logic [2:0] cfg_idx;
  wovs_item_t q_item;
  wovs_res_t  res;
  logic       q_vld, q_take, busy, res_vld;

  // register file, written in the access phase
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      if (cfg_idx == REG_TYPE_ENABLE) begin
        cfg_nxt.en = pwdata[3:0];
      end else if (cfg_idx <= REG_KEEP_MIN_3) begin
        cfg_nxt.km[2'(cfg_idx - REG_KEEP_MIN_0)] = pwdata[15:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (cfg_idx == REG_TYPE_ENABLE) begin
      prdata = {28'd0, cfg_r.en};
    end else if (cfg_idx <= REG_KEEP_MIN_3) begin
      prdata = {16'd0, cfg_r.km[2'(cfg_idx - REG_KEEP_MIN_0)]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front end: accept and decode into the command queue
  wovs_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_command     (in_command),
    .in_category    (in_category),
    .in_file_handle (in_file_handle),
    .in_file_bytes  (in_file_bytes),
    .in_stamp       (in_stamp),
    .busy           (busy),
    .q_vld          (q_vld),
    .q_item         (q_item),
    .q_take         (q_take)
  );

  // back end: runs commands against the candidate store
  wovs_back #(
    .NC  (NUM_CATEGORIES),
    .SPC (SLOTS_PER_CATEGORY),
    .TW  (TW)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_vld    (q_vld),
    .q_item   (q_item),
    .q_take   (q_take),
    .busy     (busy),
    .out_vld  (res_vld),
    .out_res  (res),
    .total    (out_pending_total),
    .out_take (pop)
  );

  // result register drives the output side directly
  assign empty               = !res_vld;
  assign out_status          = res.status;
  assign out_victim_category = res.vcat;
  assign out_victim_handle   = res.handle;
  assign out_victim_bytes    = res.bytes;
  assign out_victim_stamp    = res.stamp;

  // no result can appear during the clearing pass after reset
  a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (empty && full))
    else $error("result or accept during reset clearing pass");

  // the held count never exceeds the store
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(out_pending_total) <= NUM_CATEGORIES * SLOTS_PER_CATEGORY)
    else $error("pending total above store size");

  // a victim always comes from an existing category
  a_vcat_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (32'(out_victim_category) < NUM_CATEGORIES))
    else $error("victim category out of range");

endmodule

>>> test/weighted_oldest_victim_select_tb.sv
// testbench of the weighted oldest victim selector: directed and random commands, scoreboard check
`timescale 1ns / 100ps

module weighted_oldest_victim_select_tb;
  import wovs_pkg::*;

  localparam int NCAT  = 4;
  localparam int NSLOT = 16;
  localparam int TOTAL = NCAT * NSLOT;
  // command 3 is not an enum member, the block treats it as a no-op
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // one clear is the slowest command, allow some margin on top
  localparam int DRAIN_CYCLES = TOTAL + 30;

  typedef struct {
    wovs_status_t status;
    logic [1:0]   vcat;
    logic [15:0]  handle;
    logic [39:0]  bytes;
    logic [39:0]  stamp;
    logic [6:0]   pending;
  } victim_res_t;

  // predictor of the candidate store plus queue of expected results
  class victim_scoreboard;
    bit [3:0]    type_en;
    bit [15:0]   keep_min [NCAT];
    bit          valid [TOTAL];
    bit [39:0]   stamp [TOTAL];
    bit [39:0]   bytes [TOTAL];
    bit [15:0]   handle [TOTAL];
    bit [15:0]   age [TOTAL];
    int          cat_cnt [NCAT];
    bit [15:0]   serial;
    int          held;
    victim_res_t expected_q [$];
    int          errors;

    function void clear_store();
      foreach (valid[i]) valid[i] = 0;
      foreach (cat_cnt[c]) cat_cnt[c] = 0;
      held = 0;
    endfunction

    function void write_reg(int idx, bit [31:0] val);
      if (idx == REG_TYPE_ENABLE) type_en = val[3:0];
      else if (idx <= NCAT) keep_min[idx - REG_KEEP_MIN_0] = val[15:0];
    endfunction

    function longint unsigned eff(int c);
      return (keep_min[c] == 0) ? 64'd2147483647 : longint'(keep_min[c]);
    endfunction

    // predict the result of one accepted command
    function void note_input(logic [1:0] cmd, logic [1:0] cat, logic [15:0] h,
                             logic [39:0] b, logic [39:0] s);
      victim_res_t r;
      bit found, have;
      int best, pick;
      bit [15:0] pick_old, old;
      r = '{STAT_OK, 2'd0, 16'd0, 40'd0, 40'd0, 7'd0};
      found = 0;
      have = 0;
      best = 0;
      pick = 0;
      pick_old = 0;
      case (cmd)
        CMD_INSERT: begin
          if (!type_en[cat]) r.status = STAT_DISABLED;
          else if (cat_cnt[cat] >= NSLOT) r.status = STAT_FULL;
          else begin
            for (int k = cat * NSLOT; k < (cat + 1) * NSLOT; k++) begin
              if (!valid[k]) begin
                valid[k] = 1;
                handle[k] = h;
                bytes[k] = b;
                stamp[k] = s;
                age[k] = serial;
                serial++;
                cat_cnt[cat]++;
                held++;
                break;
              end
            end
          end
        end
        CMD_TAKE: begin
          // category with the largest count / keep_min, lowest index on a tie
          for (int c = 0; c < NCAT; c++) begin
            if (!type_en[c]) continue;
            if (!found) begin
              best = c;
              found = 1;
            end else if (longint'(cat_cnt[best]) * eff(c) < longint'(cat_cnt[c]) * eff(best))
              best = c;
          end
          if (held == 0 || !found || cat_cnt[best] == 0) r.status = STAT_NONE;
          else begin
            // oldest stamp, earliest insert on equal stamps
            for (int k = best * NSLOT; k < (best + 1) * NSLOT; k++) begin
              if (!valid[k]) continue;
              old = serial - age[k];
              if (!have || stamp[k] < stamp[pick] ||
                  (stamp[k] == stamp[pick] && old > pick_old)) begin
                pick = k;
                pick_old = old;
                have = 1;
              end
            end
            r.vcat = best[1:0];
            r.handle = handle[pick];
            r.bytes = bytes[pick];
            r.stamp = stamp[pick];
            valid[pick] = 0;
            cat_cnt[best]--;
            held--;
          end
        end
        CMD_CLEAR: clear_store();
        default: ;
      endcase
      r.pending = held[6:0];
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void check_result(victim_res_t got);
      victim_res_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, status %0d", $time, got.status);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.status !== e.status) begin
        $display("%0t: status exp %0d got %0d", $time, e.status, got.status);
        errors++;
      end
      if (got.vcat !== e.vcat) begin
        $display("%0t: victim_category exp %0d got %0d", $time, e.vcat, got.vcat);
        errors++;
      end
      if (got.handle !== e.handle) begin
        $display("%0t: victim_handle exp %h got %h", $time, e.handle, got.handle);
        errors++;
      end
      if (got.bytes !== e.bytes) begin
        $display("%0t: victim_bytes exp %h got %h", $time, e.bytes, got.bytes);
        errors++;
      end
      if (got.stamp !== e.stamp) begin
        $display("%0t: victim_stamp exp %h got %h", $time, e.stamp, got.stamp);
        errors++;
      end
      if (got.pending !== e.pending) begin
        $display("%0t: pending_total exp %0d got %0d", $time, e.pending, got.pending);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        push, full, empty, pop;
  logic [1:0]  in_command, in_category;
  logic [15:0] in_file_handle;
  logic [39:0] in_file_bytes, in_stamp;
  logic [1:0]  out_status, out_victim_category;
  logic [15:0] out_victim_handle;
  logic [39:0] out_victim_bytes, out_victim_stamp;
  logic [6:0]  out_pending_total;

  victim_scoreboard sb;
  bit sender_gaps;     // random gaps between input transactions
  bit receiver_stalls; // random stalls on the result side

  weighted_oldest_victim_select i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .push                (push),
    .full                (full),
    .in_command          (in_command),
    .in_category         (in_category),
    .in_file_handle      (in_file_handle),
    .in_file_bytes       (in_file_bytes),
    .in_stamp            (in_stamp),
    .empty               (empty),
    .pop                 (pop),
    .out_status          (out_status),
    .out_victim_category (out_victim_category),
    .out_victim_handle   (out_victim_handle),
    .out_victim_bytes    (out_victim_bytes),
    .out_victim_stamp    (out_victim_stamp),
    .out_pending_total   (out_pending_total)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return 0;
    if (p < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [39:0] rand40();
    return 40'({$urandom, $urandom});
  endfunction

  // stamps often collide so the insert-order tie break gets exercised
  function automatic logic [39:0] rand_stamp();
    return ($urandom_range(0, 1) == 1) ? 40'($urandom_range(0, 7)) : rand40();
  endfunction

  // result side: monitor samples at the rising edge
  always @(posedge clk) begin
    victim_res_t got;
    if (rst_n && pop && !empty) begin
      got.status  = wovs_status_t'(out_status);
      got.vcat    = out_victim_category;
      got.handle  = out_victim_handle;
      got.bytes   = out_victim_bytes;
      got.stamp   = out_victim_stamp;
      got.pending = out_pending_total;
      sb.check_result(got);
    end
  end

  // result side: pop changes at the falling edge, stalls of random length
  initial begin
    int stall;
    stall = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        pop = 1'b0;
        stall--;
      end else begin
        pop = 1'b1;
        if (receiver_stalls) stall = gap_len();
      end
    end
  end

  // one register write, setup then access cycle
  task automatic write_reg(int idx, logic [31:0] val);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = 5'(4 * idx);
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, val);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // one input transaction, held until accepted
  task automatic send(logic [1:0] cmd, logic [1:0] cat, logic [15:0] h,
                      logic [39:0] b, logic [39:0] s);
    int g;
    g = sender_gaps ? gap_len() : 0;
    if (g > 0) begin
      push = 1'b0;
      repeat (g) @(negedge clk);
    end
    push = 1'b1;
    in_command = cmd;
    in_category = cat;
    in_file_handle = h;
    in_file_bytes = b;
    in_stamp = s;
    do @(posedge clk); while (full);
    sb.note_input(cmd, cat, h, b, s);
    @(negedge clk);
  endtask

  // hold off the input side until every result is back and the block is idle
  task automatic drain();
    push = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_item(bit [3:0] en);
    int p;
    logic [1:0] cat;
    p = $urandom_range(0, 99);
    // mostly enabled categories, some noise to disabled ones
    cat = 2'($urandom_range(0, 3));
    if (en != 0 && $urandom_range(0, 9) != 0)
      while (!en[cat]) cat = 2'($urandom_range(0, 3));
    if (p < 56)
      send(CMD_INSERT, cat, 16'($urandom), rand40(), rand_stamp());
    else if (p < 94)
      send(CMD_TAKE, 2'($urandom), 16'($urandom), rand40(), rand40());
    else if (p < 97)
      send(CMD_CLEAR, 2'($urandom), 16'($urandom), rand40(), rand40());
    else
      send(CMD_UNUSED, 2'($urandom), 16'($urandom), rand40(), rand40());
  endtask

  function automatic logic [15:0] rand_keep();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'hFFFF;
      3: return 16'($urandom_range(1, 20));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    bit [3:0] en;
    sb = new();
    sender_gaps = 1'b1;
    receiver_stalls = 1'b1;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    push = 1'b0;
    in_command = CMD_INSERT;
    in_category = '0;
    in_file_handle = '0;
    in_file_bytes = '0;
    in_stamp = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: nothing enabled
    send(CMD_INSERT, 2'd0, 16'h1234, 40'd5, 40'd5);
    send(CMD_TAKE, 2'd0, 16'd0, 40'd0, 40'd0);
    drain();
    write_reg(REG_TYPE_ENABLE, 32'h5);
    write_reg(REG_KEEP_MIN_0, 32'd0);
    write_reg(REG_KEEP_MIN_0 + 2, 32'd1);
    // insert to a disabled category, field extremes, equal stamps
    send(CMD_INSERT, 2'd1, 16'h0001, 40'd1, 40'd1);
    send(CMD_INSERT, 2'd0, 16'hFFFF, '1, '1);
    send(CMD_INSERT, 2'd0, 16'h0000, '0, '0);
    send(CMD_INSERT, 2'd2, 16'h00AA, 40'd10, 40'd5);
    send(CMD_INSERT, 2'd2, 16'h00BB, 40'd20, 40'd5);
    send(CMD_TAKE, 2'd0, 16'd0, 40'd0, 40'd0);
    send(CMD_TAKE, 2'd0, 16'd0, 40'd0, 40'd0);
    send(CMD_TAKE, 2'd0, 16'd0, 40'd0, 40'd0);
    send(CMD_UNUSED, 2'd3, '1, '1, '1);
    send(CMD_CLEAR, 2'd0, 16'd0, 40'd0, 40'd0);
    send(CMD_TAKE, 2'd0, 16'd0, 40'd0, 40'd0);
    // fill one category past its capacity
    for (int k = 0; k <= NSLOT; k++)
      send(CMD_INSERT, 2'd2, 16'(k), 40'(k), 40'd3);
    send(CMD_TAKE, 2'd0, 16'd0, 40'd0, 40'd0);
    drain();

    // random phases, each with fresh register settings
    for (int ph = 0; ph < 17; ph++) begin
      if (ph == 0) en = 4'hF;
      else if (ph == 5) en = 4'h0;
      else en = 4'($urandom);
      sender_gaps = (ph % 4) != 3;
      receiver_stalls = (ph % 5) != 2;
      write_reg(REG_TYPE_ENABLE, 32'(en));
      for (int c = 0; c < NCAT; c++)
        write_reg(REG_KEEP_MIN_0 + c, (ph == 1) ? 32'hFFFF : 32'(rand_keep()));
      for (int n = 0; n < 100; n++) random_item(en);
      drain();
    end

    if (sb.errors == 0) $display("PASS weighted_oldest_victim_select");
    else $display("FAIL weighted_oldest_victim_select");
    $finish;
  end

  initial begin
    #60_000_000;
    $display("FAIL weighted_oldest_victim_select");
    $finish;
  end

endmodule
